// File: sv/rti_pkg.sv
// Shared types and constants for the rectilinear trilinear interpolator.
// No dependencies; every other file imports it.
package rti_pkg;

  localparam int AXIS_DEPTH_DEF = 64;
  localparam int GRID_DEPTH_DEF = 4096;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int SIZE_W      = 7;
  localparam int WORD_W      = 32;
  localparam int ADDR_W      = 12;
  localparam int IDX_W       = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int S_TDATA_W   = 112;
  localparam int S_TUSER_W   = 4;
  localparam int M_TDATA_W   = 96;
  localparam int DIV_W       = 24;
  localparam int DIV_CNT_W   = 5;
  localparam int QUEUE_DEPTH = 4;
  localparam int QP_W        = 2;

  typedef enum logic [1:0] {
    ACT_AXIS_WR = 2'd0,
    ACT_GRID_WR = 2'd1,
    ACT_QUERY   = 2'd2
  } action_t;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

  typedef enum logic [1:0] {
    KIND_AXIS_WR,
    KIND_GRID_WR,
    KIND_QUERY
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic [1:0]                axis;
    logic [ADDR_W-1:0]         addr;
    logic signed [WORD_W-1:0]  a;
    logic signed [WORD_W-1:0]  b;
    logic signed [WORD_W-1:0]  c;
    logic                      last;
  } cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0]    rem0;
    logic [DIV_W-1:0]     low0;
    logic [WORD_W-1:0]    den;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MIN, ST_MAX, ST_CHK, ST_GDIV, ST_G0A, ST_G0B, ST_G1,
    ST_BADDR, ST_BCMP, ST_FLO, ST_FHI, ST_FHI2, ST_FRAC, ST_FDIV, ST_NEXT,
    ST_MUL1, ST_MUL2, ST_BASE, ST_FETCH, ST_LMUL, ST_LADD, ST_OUT
  } state_t;

endpackage

// File: sv/rti_fifo.sv
// Short command queue between the front and back ends.
// Depends on rti_pkg.
module rti_fifo import rti_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  cmd_t            slots [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr;
  logic [QP_W-1:0] rd_ptr;
  logic [QP_W:0]   count;

  assign full  = (count == (QP_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= din;
  end

endmodule

// File: sv/rti_front.sv
// Front end: unpacks input transfers, classifies them and drops ignored ones.
// Depends on rti_pkg.
module rti_front import rti_pkg::*; #(
  parameter int AXIS_DEPTH = AXIS_DEPTH_DEF,
  parameter int GRID_DEPTH = GRID_DEPTH_DEF
) (
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [S_TUSER_W-1:0] s_tuser,
  input  logic                 s_tlast,
  input  logic                 full,
  output logic                 push,
  output cmd_t                 cmd
);

  logic [1:0]       act;
  logic [IDX_W-1:0] addr_ext;
  logic             keep;

  assign act      = s_tuser[1:0];
  assign addr_ext = IDX_W'(s_tdata[ADDR_W-1:0]);

  always_comb begin
    cmd.axis = s_tuser[3:2];
    cmd.addr = s_tdata[ADDR_W-1:0];
    cmd.a    = s_tdata[ADDR_W +: WORD_W];
    cmd.b    = s_tdata[ADDR_W+WORD_W +: WORD_W];
    cmd.c    = s_tdata[ADDR_W+2*WORD_W +: WORD_W];
    cmd.last = s_tlast;
    cmd.kind = KIND_QUERY;
    keep     = 1'b0;
    unique case (act)
      ACT_AXIS_WR: begin
        cmd.kind = KIND_AXIS_WR;
        keep = (cmd.axis == AXIS_X || cmd.axis == AXIS_Y || cmd.axis == AXIS_Z)
               && (addr_ext < IDX_W'(AXIS_DEPTH));
      end
      ACT_GRID_WR: begin
        cmd.kind = KIND_GRID_WR;
        keep = (addr_ext < IDX_W'(GRID_DEPTH));
      end
      ACT_QUERY: begin
        cmd.kind = KIND_QUERY;
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign s_tready = !full;
  assign push     = s_tvalid && !full && keep;

endmodule

// File: sv/rti_div.sv
// Restoring divider, one quotient bit per cycle, remainder below divisor.
// Depends on rti_pkg.
module rti_div import rti_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  div_req_t         req,
  output logic             done,
  output logic [DIV_W-1:0] q
);

  logic                 busy;
  logic [WORD_W-1:0]    rem;
  logic [DIV_W-1:0]     low;
  logic [WORD_W-1:0]    den;
  logic [DIV_CNT_W-1:0] cnt;
  logic [WORD_W:0]      trial;
  logic [WORD_W:0]      diff;

  assign done  = busy && (cnt == '0);
  assign trial = {rem, low[DIV_W-1]};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= req.rem0;
      low <= req.low0;
      den <= req.den;
      cnt <= req.steps;
      q   <= '0;
    end else if (busy && cnt != '0) begin
      if (trial >= {1'b0, den}) begin
        rem <= diff[WORD_W-1:0];
        q   <= {q[DIV_W-2:0], 1'b1};
      end else begin
        rem <= trial[WORD_W-1:0];
        q   <= {q[DIV_W-2:0], 1'b0};
      end
      low <= {low[DIV_W-2:0], 1'b0};
      cnt <= cnt - 1'b1;
    end
  end

endmodule

// File: sv/rti_back.sv
// Back end: table and grid memories, axis search, fractions and the blend.
// Depends on rti_pkg and rti_div.
module rti_back import rti_pkg::*; #(
  parameter int AXIS_DEPTH = AXIS_DEPTH_DEF,
  parameter int GRID_DEPTH = GRID_DEPTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cmd_t                        head,
  input  logic                        empty,
  output logic                        pop,
  input  logic [$clog2(AXIS_DEPTH):0] n_x,
  input  logic [$clog2(AXIS_DEPTH):0] n_y,
  input  logic [$clog2(AXIS_DEPTH):0] n_z,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [M_TDATA_W-1:0]        m_tdata,
  output logic [0:0]                  m_tuser,
  output logic                        m_tlast
);

  localparam int AXW = $clog2(AXIS_DEPTH);
  localparam int NW  = AXW + 1;
  localparam int GAW = $clog2(GRID_DEPTH);
  localparam int FW  = FRAC_BITS + 1;
  localparam int LW  = WORD_W + FRAC_BITS + 3;
  localparam int PW  = WORD_W + AXW;
  localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;
  localparam logic signed [LW-1:0] HALF = LW'(1) << (FRAC_BITS - 1);

  state_t state, state_next;

  logic signed [WORD_W-1:0] tab_x [AXIS_DEPTH];
  logic signed [WORD_W-1:0] tab_y [AXIS_DEPTH];
  logic signed [WORD_W-1:0] tab_z [AXIS_DEPTH];
  logic signed [WORD_W-1:0] grd_x [GRID_DEPTH];
  logic signed [WORD_W-1:0] grd_y [GRID_DEPTH];
  logic signed [WORD_W-1:0] grd_z [GRID_DEPTH];
  logic signed [WORD_W-1:0] tq_x, tq_y, tq_z, gq_x, gq_y, gq_z;

  cmd_t                     cur;
  logic [1:0]               axis;
  logic signed [WORD_W-1:0] mn, glo, ghi;
  logic [AXW-1:0]           mid, lo, hi, xi, yi, zi;
  logic [FW-1:0]            frac, fx, fy, fz;
  logic [IDX_W-1:0]         t1, b000, b100, nyz;
  logic [3:0]               k, cnt;
  logic [2:0]               step;
  logic                     oob_d, oor;
  logic signed [WORD_W-1:0] w  [3][8];
  logic signed [LW-1:0]     p1 [3];
  logic signed [LW-1:0]     p2 [3];

  logic                     ax_we, gr_we, out_load, div_start, div_done, go_div;
  logic [AXW-1:0]           ax_ra;
  logic [GAW-1:0]           g_ra, g_wa;
  logic [IDX_W-1:0]         head_addr, caddr;
  logic signed [WORD_W-1:0] v, gq;
  logic [NW-1:0]            n_cur;
  logic [AXW-1:0]           hi_max, q_ax, mid_g;
  logic signed [WORD_W:0]   d_mn, d_mx, num, den;
  logic [PW-1:0]            prod;
  logic [DIV_W-1:0]         div_q;
  div_req_t                 div_req;
  logic [FW-1:0]            fsel, omf;
  logic signed [LW-1:0]     sum [3];
  logic signed [WORD_W-1:0] res [3];
  logic [2:0]               wpos;

  always_comb begin
    unique case (axis)
      AXIS_X:  begin v = cur.a; n_cur = n_x; gq = tq_x; end
      AXIS_Y:  begin v = cur.b; n_cur = n_y; gq = tq_y; end
      default: begin v = cur.c; n_cur = n_z; gq = tq_z; end
    endcase
  end

  assign hi_max    = AXW'(n_cur - 1'b1);
  assign d_mn      = (WORD_W+1)'(v) - (WORD_W+1)'(mn);
  assign d_mx      = (WORD_W+1)'(gq) - (WORD_W+1)'(mn);
  assign num       = (WORD_W+1)'(v) - (WORD_W+1)'(glo);
  assign den       = (WORD_W+1)'(ghi) - (WORD_W+1)'(glo);
  assign prod      = PW'(d_mn[WORD_W-1:0]) * PW'(hi_max);
  assign q_ax      = div_q[AXW-1:0];
  assign mid_g     = (q_ax > hi_max - 1'b1) ? hi_max - 1'b1 : q_ax;
  assign head_addr = IDX_W'(head.addr);
  assign g_wa      = head_addr[GAW-1:0];
  assign caddr     = (k[0] ? b100 : b000) + (k[1] ? IDX_W'(n_z) : '0) + IDX_W'(k[2]);
  assign g_ra      = caddr[GAW-1:0];
  assign fsel      = (step < 3'd4) ? fx : ((step < 3'd6) ? fy : fz);
  assign omf       = ONE - fsel;
  assign wpos      = 3'(cnt - 4'd2);

  always_comb begin
    div_req.rem0  = num[WORD_W-1:0];
    div_req.low0  = '0;
    div_req.den   = den[WORD_W-1:0];
    div_req.steps = DIV_CNT_W'(FRAC_BITS);
    if (state == ST_CHK) begin
      div_req.rem0  = WORD_W'(prod >> AXW);
      div_req.low0  = DIV_W'(prod[AXW-1:0]) << (DIV_W - AXW);
      div_req.den   = d_mx[WORD_W-1:0];
      div_req.steps = DIV_CNT_W'(AXW);
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    assign sum[c] = p1[c] + p2[c] + HALF;
    assign res[c] = WORD_W'(sum[c] >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    ax_we      = 1'b0;
    gr_we      = 1'b0;
    out_load   = 1'b0;
    div_start  = 1'b0;
    go_div     = (d_mn >= 0) && (num > 0) && (den > 0) && (num < den);
    ax_ra      = mid;
    unique case (state)
      ST_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          unique case (head.kind)
            KIND_AXIS_WR: ax_we = 1'b1;
            KIND_GRID_WR: gr_we = 1'b1;
            default:      state_next = ST_MIN;
          endcase
        end
      end
      ST_MIN: begin
        ax_ra = '0;
        state_next = ST_MAX;
      end
      ST_MAX: begin
        ax_ra = hi_max;
        state_next = ST_CHK;
      end
      ST_CHK: begin
        if (v < mn || v > gq) begin
          state_next = ST_OUT;
        end else if (gq > mn) begin
          div_start = 1'b1;
          state_next = ST_GDIV;
        end else begin
          state_next = ST_G0A;
        end
      end
      ST_GDIV:  if (div_done) state_next = ST_G0A;
      ST_G0A:   state_next = ST_G0B;
      ST_G0B: begin
        ax_ra = mid + 1'b1;
        state_next = ST_G1;
      end
      ST_G1: begin
        if (v >= glo && v <= gq) state_next = ST_FRAC;
        else                     state_next = ST_BADDR;
      end
      ST_BADDR: begin
        if (hi - lo == AXW'(1)) state_next = ST_FLO;
        else                    state_next = ST_BCMP;
      end
      ST_BCMP:  state_next = ST_BADDR;
      ST_FLO: begin
        ax_ra = lo;
        state_next = ST_FHI;
      end
      ST_FHI: begin
        ax_ra = hi;
        state_next = ST_FHI2;
      end
      ST_FHI2:  state_next = ST_FRAC;
      ST_FRAC: begin
        if (go_div) begin
          div_start = 1'b1;
          state_next = ST_FDIV;
        end else begin
          state_next = ST_NEXT;
        end
      end
      ST_FDIV:  if (div_done) state_next = ST_NEXT;
      ST_NEXT:  state_next = (axis == AXIS_Z) ? ST_MUL1 : ST_MIN;
      ST_MUL1:  state_next = ST_MUL2;
      ST_MUL2:  state_next = ST_BASE;
      ST_BASE:  state_next = ST_FETCH;
      ST_FETCH: if (k == 4'd8) state_next = ST_LMUL;
      ST_LMUL:  state_next = ST_LADD;
      ST_LADD:  state_next = (step == 3'd6) ? ST_OUT : ST_LMUL;
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (ax_we && head.axis == AXIS_X) tab_x[head.addr[AXW-1:0]] <= head.a;
    if (ax_we && head.axis == AXIS_Y) tab_y[head.addr[AXW-1:0]] <= head.a;
    if (ax_we && head.axis == AXIS_Z) tab_z[head.addr[AXW-1:0]] <= head.a;
    tq_x <= tab_x[ax_ra];
    tq_y <= tab_y[ax_ra];
    tq_z <= tab_z[ax_ra];
  end

  always_ff @(posedge clk) begin
    if (gr_we) begin
      grd_x[g_wa] <= head.a;
      grd_y[g_wa] <= head.b;
      grd_z[g_wa] <= head.c;
    end
    gq_x <= grd_x[g_ra];
    gq_y <= grd_y[g_ra];
    gq_z <= grd_z[g_ra];
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        cur  <= head;
        axis <= AXIS_X;
        oor  <= 1'b0;
      end
      ST_MAX: mn <= gq;
      ST_CHK: begin
        if (v < mn || v > gq) oor <= 1'b1;
        mid <= '0;
      end
      ST_GDIV: if (div_done) mid <= mid_g;
      ST_G0B:  glo <= gq;
      ST_G1: begin
        ghi <= gq;
        if (v >= glo && v <= gq) begin
          lo <= mid;
          hi <= mid + 1'b1;
        end else begin
          lo  <= '0;
          hi  <= hi_max;
          mid <= hi_max >> 1;
        end
      end
      ST_BCMP: begin
        if (v < gq) begin
          hi  <= mid;
          mid <= lo + ((mid - lo) >> 1);
        end else begin
          lo  <= mid;
          mid <= mid + ((hi - mid) >> 1);
        end
      end
      ST_FHI:  glo <= gq;
      ST_FHI2: ghi <= gq;
      ST_FRAC: begin
        if (d_mn < 0 || num <= 0 || den <= 0) frac <= '0;
        else if (num >= den)                  frac <= ONE;
      end
      ST_FDIV: if (div_done) frac <= FW'(div_q[FRAC_BITS-1:0]);
      ST_NEXT: begin
        unique case (axis)
          AXIS_X:  begin xi <= lo; fx <= frac; end
          AXIS_Y:  begin yi <= lo; fy <= frac; end
          default: begin zi <= lo; fz <= frac; end
        endcase
        axis <= axis + 1'b1;
      end
      ST_MUL1: t1 <= IDX_W'(xi) * IDX_W'(n_y) + IDX_W'(yi);
      ST_MUL2: begin
        b000 <= t1 * IDX_W'(n_z) + IDX_W'(zi);
        nyz  <= IDX_W'(n_y) * IDX_W'(n_z);
      end
      ST_BASE: begin
        b100 <= b000 + nyz;
        k    <= '0;
      end
      ST_FETCH: begin
        oob_d <= (caddr >= IDX_W'(GRID_DEPTH));
        if (k != '0) begin
          w[0][3'(k - 1'b1)] <= oob_d ? '0 : gq_x;
          w[1][3'(k - 1'b1)] <= oob_d ? '0 : gq_y;
          w[2][3'(k - 1'b1)] <= oob_d ? '0 : gq_z;
        end
        k    <= k + 1'b1;
        cnt  <= 4'd8;
        step <= '0;
      end
      ST_LMUL: begin
        for (int c = 0; c < 3; c++) begin
          p1[c] <= LW'(w[c][0]) * LW'($signed({1'b0, omf}));
          p2[c] <= LW'(w[c][1]) * LW'($signed({1'b0, fsel}));
        end
      end
      ST_LADD: begin
        for (int c = 0; c < 3; c++) begin
          for (int i = 0; i < 6; i++) w[c][i] <= w[c][i+2];
          w[c][wpos] <= res[c];
        end
        cnt  <= cnt - 1'b1;
        step <= step + 1'b1;
      end
      default: ;
    endcase
  end

  rti_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .req   (div_req),
    .done  (div_done),
    .q     (div_q)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= oor;
      m_tlast <= cur.last;
      m_tdata <= oor ? '0 : {w[2][0], w[1][0], w[0][0]};
    end
  end

endmodule

// File: sv/rectilinear_trilinear_interp.sv
// Trilinear interpolation on a rectilinear grid, Q16.16; one write applied per cycle when idle.
// Each axis cell is first guessed by a division, with a binary search on a miss; a flat axis
// skips the guess division and a fraction found without division skips the divider; a query
// out of range ends at the failing axis. Queries run one at a time through the back-end
// sequencer and its shared divider.
// Synchronous active-high reset clears control and sets sizes to 2; memories are not cleared.
module rectilinear_trilinear_interp import rti_pkg::*; #(
  parameter int AXIS_DEPTH = AXIS_DEPTH_DEF,
  parameter int GRID_DEPTH = GRID_DEPTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // address, word_a, word_b, word_c, pad
  input  logic [S_TUSER_W-1:0] s_tuser,   // action, axis_select
  input  logic                 s_tlast,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // value_x, value_y, value_z
  output logic [0:0]           m_tuser,   // status
  output logic                 m_tlast,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  localparam int NW = $clog2(AXIS_DEPTH) + 1;
  localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(2);

  logic [SIZE_W-1:0] size_x, size_y, size_z;
  logic [NW-1:0]     n_x, n_y, n_z;
  logic              full, empty, push, pop;
  cmd_t              cmd_in, cmd_head;

  function automatic logic [NW-1:0] eff_size(input logic [SIZE_W-1:0] s);
    if (s < SIZE_MIN) return NW'(2);
    if (32'(s) > AXIS_DEPTH) return NW'(AXIS_DEPTH);
    return NW'(s);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= SIZE_MIN;
      size_y <= SIZE_MIN;
      size_z <= SIZE_MIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SIZE_X: size_x <= cfg_data;
        REG_SIZE_Y: size_y <= cfg_data;
        REG_SIZE_Z: size_z <= cfg_data;
        default: ;
      endcase
    end
  end

  assign n_x = eff_size(size_x);
  assign n_y = eff_size(size_y);
  assign n_z = eff_size(size_z);

  rti_front #(
    .AXIS_DEPTH (AXIS_DEPTH),
    .GRID_DEPTH (GRID_DEPTH)
  ) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .full     (full),
    .push     (push),
    .cmd      (cmd_in)
  );

  rti_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (cmd_in),
    .full  (full),
    .pop   (pop),
    .dout  (cmd_head),
    .empty (empty)
  );

  rti_back #(
    .AXIS_DEPTH (AXIS_DEPTH),
    .GRID_DEPTH (GRID_DEPTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (cmd_head),
    .empty    (empty),
    .pop      (pop),
    .n_x      (n_x),
    .n_y      (n_y),
    .n_z      (n_z),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// File: sv/rti_checker.sv
// Port-level checks on the result stream of the interpolator.
// Depends on rti_pkg; bound to rectilinear_trilinear_interp below.
module rti_checker import rti_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [0:0]           m_tuser,
  input logic                 m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("result changed while stalled");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("out-of-range result carries nonzero data");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid straight after reset");

  a_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(m_tvalid) |-> $past(m_tready))
    else $error("result withdrawn without a transfer");

endmodule

bind rectilinear_trilinear_interp rti_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// File: tb/rectilinear_trilinear_interp_tb.sv
// Self-checking testbench for the rectilinear trilinear interpolator: loads axis tables
// and grid vectors, fires query points and checks each result against a built-in predictor.
// Depends on rti_pkg and rectilinear_trilinear_interp.
module rectilinear_trilinear_interp_tb;
  import rti_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_NOP   = 2'd3;
  localparam logic [1:0] AXIS_NONE = 2'd3;
  localparam int LIMIT   = 1000000;
  localparam int ONE_Q   = 1 << FRAC_BITS_DEF;
  localparam int T_UNI   = 0;
  localparam int T_RAND  = 1;
  localparam int T_FLAT  = 2;
  localparam int T_SHUF  = 3;
  localparam int T_SPAN  = 4;
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  typedef struct {
    logic [1:0]  act;
    logic [1:0]  sel;
    logic [11:0] addr;
    logic [31:0] a, b, c;
    logic        last;
  } xfer_t;

  typedef struct {
    logic        status;
    logic [31:0] vx, vy, vz;
    logic        last;
  } point_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic                 s_tlast = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [0:0]           m_tuser;
  logic                 m_tlast;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SIZE_W-1:0]    cfg_data = '0;

  rectilinear_trilinear_interp dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  xfer_t       pending[$];
  point_t      points_due[$];
  xfer_t       cur;
  int          errors = 0;
  int          cycles = 0;
  int          idle_mode = IDLE_NONE;
  logic [6:0]  size_reg[3] = '{7'd2, 7'd2, 7'd2};
  int          coord_tab[3][64];
  int          field_mem[3][4096];
  int          plan_tab[3][64];
  int          plan_n[3];
  int          grid_hw = 0;

  function automatic int eff_size(logic [6:0] s);
    if (s < 2) return 2;
    if (s > 64) return 64;
    return s;
  endfunction

  function automatic bit find_cell(int v, int ax, int n, output int idx, output longint frac);
    int     hi = n - 1;
    int     lo = 0;
    int     mid;
    longint mn, mx, num, den, q;
    mn = coord_tab[ax][0];
    mx = coord_tab[ax][hi];
    if (v < mn || v > mx) return 0;
    mid = (mx > mn) ? int'((longint'(hi) * (longint'(v) - mn)) / (mx - mn)) : 0;
    if (mid > hi - 1) mid = hi - 1;
    if (mid < 0) mid = 0;
    if (v >= coord_tab[ax][mid] && v <= coord_tab[ax][mid+1]) begin
      lo = mid;
      hi = mid + 1;
    end else begin
      mid = (hi - lo) / 2;
      while (hi - lo != 1) begin
        if (v < coord_tab[ax][mid]) hi = mid; else lo = mid;
        mid = lo + (hi - lo) / 2;
      end
    end
    idx = lo;
    num = longint'(v) - coord_tab[ax][lo];
    den = longint'(coord_tab[ax][hi]) - coord_tab[ax][lo];
    if (den <= 0 || num <= 0) frac = 0;
    else begin
      q = (num <<< FRAC_BITS_DEF) / den;
      frac = (q > ONE_Q) ? ONE_Q : q;
    end
    return 1;
  endfunction

  function automatic longint blend(longint a, longint b, longint f);
    longint s;
    s = a * (ONE_Q - f) + b * f + (ONE_Q / 2);
    return s >>> FRAC_BITS_DEF;
  endfunction

  function automatic longint corner(int k, longint i);
    return (i < 4096) ? longint'(field_mem[k][i]) : 0;
  endfunction

  task automatic predict_point(xfer_t t);
    point_t p;
    int     n[3];
    int     ci[3];
    longint fr[3];
    int     w[3];
    bit     ok;
    longint b0, b1, c00, c01, c10, c11, c0, c1, r;
    if (t.act == ACT_AXIS_WR) begin
      if (t.addr < 64 && t.sel != AXIS_NONE) coord_tab[t.sel][t.addr] = t.a;
    end else if (t.act == ACT_GRID_WR) begin
      field_mem[0][t.addr] = t.a;
      field_mem[1][t.addr] = t.b;
      field_mem[2][t.addr] = t.c;
    end else if (t.act == ACT_QUERY) begin
      w = '{t.a, t.b, t.c};
      for (int i = 0; i < 3; i++) n[i] = eff_size(size_reg[i]);
      ok = 1;
      for (int i = 0; i < 3; i++) if (ok) ok = find_cell(w[i], i, n[i], ci[i], fr[i]);
      p.status = !ok;
      p.last = t.last;
      p.vx = '0; p.vy = '0; p.vz = '0;
      if (ok) begin
        b0 = (longint'(ci[0]) * n[1] + ci[1]) * n[2] + ci[2];
        b1 = b0 + n[1] * n[2];
        for (int k = 0; k < 3; k++) begin
          c00 = blend(corner(k, b0), corner(k, b1), fr[0]);
          c01 = blend(corner(k, b0 + 1), corner(k, b1 + 1), fr[0]);
          c10 = blend(corner(k, b0 + n[2]), corner(k, b1 + n[2]), fr[0]);
          c11 = blend(corner(k, b0 + n[2] + 1), corner(k, b1 + n[2] + 1), fr[0]);
          c0 = blend(c00, c10, fr[1]);
          c1 = blend(c01, c11, fr[1]);
          r = blend(c0, c1, fr[2]);
          if (k == 0) p.vx = r[31:0];
          else if (k == 1) p.vy = r[31:0];
          else p.vz = r[31:0];
        end
      end
      points_due.insert(points_due.size(), p);
    end
  endtask

  function automatic bit hold_send();
    if (idle_mode == IDLE_SEND) return $urandom_range(99) < 85;
    if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 16;
    return 0;
  endfunction

  function automatic bit hold_recv();
    if (idle_mode == IDLE_RECV) return $urandom_range(99) < 85;
    if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 16;
    return 0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_point(cur);
      if (!s_tvalid || s_tready) begin
        if (pending.size() > 0 && !hold_send()) begin
          cur = pending.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {4'b0, cur.c, cur.b, cur.a, cur.addr};
          s_tuser <= {cur.sel, cur.act};
          s_tlast <= cur.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    point_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (points_due.size() == 0) begin
          errors++;
          $error("unexpected result transfer");
        end else begin
          e = points_due.pop_front();
          if (m_tuser[0] !== e.status) begin
            errors++;
            $error("status: expected %0d, got %0d", e.status, m_tuser[0]);
          end
          if (m_tdata[31:0] !== e.vx) begin
            errors++;
            $error("value_x: expected %h, got %h", e.vx, m_tdata[31:0]);
          end
          if (m_tdata[63:32] !== e.vy) begin
            errors++;
            $error("value_y: expected %h, got %h", e.vy, m_tdata[63:32]);
          end
          if (m_tdata[95:64] !== e.vz) begin
            errors++;
            $error("value_z: expected %h, got %h", e.vz, m_tdata[95:64]);
          end
          if (m_tlast !== e.last) begin
            errors++;
            $error("batch_end: expected %0d, got %0d", e.last, m_tlast);
          end
        end
      end
      m_tready <= !hold_recv();
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("rectilinear_trilinear_interp_tb: done, errors");
      $finish;
    end
  end

  task automatic push_item(logic [1:0] act, logic [1:0] sel, logic [11:0] addr,
                           logic [31:0] a, logic [31:0] b, logic [31:0] c, logic last);
    xfer_t t;
    t.act = act; t.sel = sel; t.addr = addr; t.a = a; t.b = b; t.c = c; t.last = last;
    pending.insert(pending.size(), t);
  endtask

  task automatic push_query(int a, int b, int c);
    push_item(ACT_QUERY, 2'($urandom), 12'($urandom), a, b, c, 1'($urandom));
  endtask

  task automatic wait_idle();
    while (pending.size() > 0 || s_tvalid || points_due.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [6:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    size_reg[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic build_axis(int ax, int n, int kind);
    int base;
    base = int'($urandom_range(1 << 25)) - (1 << 24);
    for (int j = 0; j < n; j++) begin
      case (kind)
        T_UNI: plan_tab[ax][j] = base + j * 1000;
        T_RAND: plan_tab[ax][j] = (j == 0) ? base :
          plan_tab[ax][j-1] + (($urandom_range(3) == 0) ? 0 : $urandom_range(1, 1 << 20));
        T_FLAT: plan_tab[ax][j] = base;
        T_SHUF: plan_tab[ax][j] = base + int'($urandom_range(1 << 24)) - (1 << 23);
        default: plan_tab[ax][j] = int'(-64'sd2147483648 + (longint'(j) * 64'sd4294967295) / (n - 1));
      endcase
    end
    if (kind == T_SHUF) begin
      plan_tab[ax][0] = base - (1 << 24);
      plan_tab[ax][n-1] = base + (1 << 24);
    end
    if (kind == T_UNI && $urandom_range(1)) begin
      for (int j = 1; j < n; j++) plan_tab[ax][j] = base + j * 65536 + $urandom_range(20);
    end
    for (int j = 0; j < n; j++)
      push_item(ACT_AXIS_WR, 2'(ax), 12'(j), plan_tab[ax][j], $urandom, $urandom, 1'($urandom));
  endtask

  task automatic load_grid(int total);
    int top;
    top = (total > 4096) ? 4096 : total;
    for (int i = grid_hw; i < top; i++)
      push_item(ACT_GRID_WR, 2'($urandom), 12'(i), $urandom, $urandom, $urandom, 1'($urandom));
    if (top > grid_hw) grid_hw = top;
    repeat (12)
      push_item(ACT_GRID_WR, 2'($urandom), 12'($urandom_range(grid_hw - 1)),
                $urandom, $urandom, $urandom, 1'($urandom));
  endtask

  function automatic int in_range_coord(int ax);
    longint span;
    int     n;
    n = plan_n[ax];
    if ($urandom_range(3) == 0) return plan_tab[ax][$urandom_range(n - 1)];
    span = longint'(plan_tab[ax][n-1]) - plan_tab[ax][0];
    return int'(plan_tab[ax][0] + (longint'($urandom) % (span + 1)));
  endfunction

  function automatic int off_range_coord(int ax);
    int lo, hi;
    lo = plan_tab[ax][0];
    hi = plan_tab[ax][plan_n[ax]-1];
    case ($urandom_range(3))
      0: return (lo == -32'sd2147483648) ? int'($urandom) : lo - 1;
      1: return (hi == 32'sd2147483647) ? int'($urandom) : hi + 1;
      2: return int'($urandom);
      default: return $urandom_range(1) ? -32'sd2147483648 : 32'sd2147483647;
    endcase
  endfunction

  task automatic random_query();
    int w[3];
    int bad;
    bad = ($urandom_range(99) < 15) ? $urandom_range(2) : -1;
    for (int i = 0; i < 3; i++) w[i] = (i == bad) ? off_range_coord(i) : in_range_coord(i);
    push_query(w[0], w[1], w[2]);
  endtask

  task automatic noise();
    push_item(ACT_NOP, 2'($urandom), 12'($urandom), $urandom, $urandom, $urandom, 1'($urandom));
    push_item(ACT_AXIS_WR, AXIS_NONE, 12'($urandom_range(63)), $urandom, $urandom, $urandom, 1'b1);
    push_item(ACT_AXIS_WR, 2'($urandom_range(2)), 12'($urandom_range(64, 4095)),
              $urandom, $urandom, $urandom, 1'b0);
  endtask

  task automatic run_phase(int r0, int r1, int r2, int k0, int k1, int k2, int nq, int mode);
    wait_idle();
    idle_mode = mode;
    set_reg(REG_SIZE_X, 7'(r0));
    set_reg(REG_SIZE_Y, 7'(r1));
    set_reg(REG_SIZE_Z, 7'(r2));
    for (int i = 0; i < 3; i++) plan_n[i] = eff_size(size_reg[i]);
    build_axis(0, plan_n[0], k0);
    build_axis(1, plan_n[1], k1);
    build_axis(2, plan_n[2], k2);
    load_grid(plan_n[0] * plan_n[1] * plan_n[2]);
    noise();
    repeat (nq) random_query();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    run_phase(2, 2, 2, T_UNI, T_UNI, T_UNI, 0, IDLE_NONE);
    // corners, midpoint, just outside the low x face and the high y and z faces, both word extremes
    push_query(plan_tab[0][0], plan_tab[1][0], plan_tab[2][0]);
    push_query(plan_tab[0][1], plan_tab[1][1], plan_tab[2][1]);
    push_query(plan_tab[0][0], plan_tab[1][1], plan_tab[2][0]);
    push_query((plan_tab[0][0] + plan_tab[0][1]) / 2, (plan_tab[1][0] + plan_tab[1][1]) / 2,
               (plan_tab[2][0] + plan_tab[2][1]) / 2);
    push_query(plan_tab[0][0] - 1, plan_tab[1][0], plan_tab[2][0]);
    push_query(plan_tab[0][1], plan_tab[1][1] + 1, plan_tab[2][1]);
    push_query(plan_tab[0][1], plan_tab[1][1], plan_tab[2][1] + 1);
    push_query(-32'sd2147483648, -32'sd2147483648, -32'sd2147483648);
    push_query(32'sd2147483647, 32'sd2147483647, 32'sd2147483647);
    noise();
    repeat (6) random_query();
    run_phase(5, 3, 4, T_RAND, T_RAND, T_RAND, 80, IDLE_SEND);
    run_phase(64, 2, 2, T_UNI, T_RAND, T_SPAN, 70, IDLE_RECV);
    run_phase(0, 64, 1, T_SPAN, T_UNI, T_FLAT, 70, IDLE_BOTH);
    run_phase(2, 2, 127, T_FLAT, T_SHUF, T_RAND, 70, IDLE_NONE);
    run_phase(3, 4, 3, T_SHUF, T_RAND, T_UNI, 80, IDLE_SEND);
    wait_idle();
    if (errors == 0) $display("rectilinear_trilinear_interp_tb: done, clean");
    else $display("rectilinear_trilinear_interp_tb: done, errors");
    $finish;
  end

endmodule

// File: sim.f
sv/rti_pkg.sv
sv/rti_fifo.sv
sv/rti_front.sv
sv/rti_div.sv
sv/rti_back.sv
sv/rectilinear_trilinear_interp.sv
sv/rti_checker.sv
tb/rectilinear_trilinear_interp_tb.sv
